// ===== hdl/lspp_pkg.sv =====
`timescale 1ns / 1ps
package lspp_pkg;

  localparam logic [7:0]  SYNC1          = 8'hAA;
  localparam logic [7:0]  SYNC2          = 8'h55;
  localparam logic [7:0]  FRAME_END_TYPE = 8'd1;
  localparam logic [15:0] LIMIT_RST      = 16'd1000;
  localparam int          CORDIC_STEPS   = 24;
  localparam logic [34:0] XSCALE         = 35'd901500;
  localparam logic [21:0] DIST_OFFSET    = 22'd9015;

  typedef struct packed {
    logic ld_type;
    logic ld_count;
    logic ld_fsa_lo;
    logic ld_fsa_hi;
    logic ld_lsa_lo;
    logic ld_lsa_hi;
    logic clr_index;
    logic ld_smp_lo;
    logic start_calc;
    logic inc_index;
    logic push_point;
    logic push_marker;
    logic point_last;
  } lspp_cmd_t;

  typedef struct packed {
    logic is_sync1;
    logic is_sync2;
    logic total_zero;
    logic last_sample;
    logic type_end;
    logic below_max;
    logic calc_done;
    logic out_free;
  } lspp_sts_t;

  // atan(2^-k) in units of 2^-16 of 1/64 degree.
  function automatic logic [28:0] atan_lut(input logic [4:0] k);
    logic [28:0] v;
    case (k)
      5'd0:  v = 29'd188743680;
      5'd1:  v = 29'd111421900;
      5'd2:  v = 29'd58872272;
      5'd3:  v = 29'd29884485;
      5'd4:  v = 29'd15000234;
      5'd5:  v = 29'd7507429;
      5'd6:  v = 29'd3754631;
      5'd7:  v = 29'd1877430;
      5'd8:  v = 29'd938729;
      5'd9:  v = 29'd469366;
      5'd10: v = 29'd234683;
      5'd11: v = 29'd117342;
      5'd12: v = 29'd58671;
      5'd13: v = 29'd29335;
      5'd14: v = 29'd14668;
      5'd15: v = 29'd7334;
      5'd16: v = 29'd3667;
      5'd17: v = 29'd1833;
      5'd18: v = 29'd917;
      5'd19: v = 29'd458;
      5'd20: v = 29'd229;
      5'd21: v = 29'd115;
      5'd22: v = 29'd57;
      5'd23: v = 29'd29;
      default: v = 29'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/lspp_ctrl.sv =====
`timescale 1ns / 1ps
module lspp_ctrl
  import lspp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  lspp_sts_t sts,
  output lspp_cmd_t cmd
);

  typedef enum logic [3:0] {
    PH_HUNT, PH_SYNC2, PH_TYPE, PH_COUNT, PH_FSA_LO, PH_FSA_HI,
    PH_LSA_LO, PH_LSA_HI, PH_CS_LO, PH_CS_HI, PH_SMP_LO, PH_SMP_HI
  } phase_t;

  typedef enum logic [1:0] {S_IDLE, S_CALC, S_PT, S_MK} state_t;

  phase_t phase_r, phase_nxt;
  state_t state_r, state_nxt;
  logic   end_r, end_nxt;
  logic   acc;

  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    cmd       = '0;
    phase_nxt = phase_r;
    state_nxt = state_r;
    end_nxt   = end_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          unique case (phase_r)
            PH_HUNT:   if (sts.is_sync1) phase_nxt = PH_SYNC2;
            PH_SYNC2:  phase_nxt = sts.is_sync2 ? PH_TYPE : PH_HUNT;
            PH_TYPE: begin
              cmd.ld_type = 1'b1;
              phase_nxt   = PH_COUNT;
            end
            PH_COUNT: begin
              cmd.ld_count = 1'b1;
              phase_nxt    = PH_FSA_LO;
            end
            PH_FSA_LO: begin
              cmd.ld_fsa_lo = 1'b1;
              phase_nxt     = PH_FSA_HI;
            end
            PH_FSA_HI: begin
              cmd.ld_fsa_hi = 1'b1;
              phase_nxt     = PH_LSA_LO;
            end
            PH_LSA_LO: begin
              cmd.ld_lsa_lo = 1'b1;
              phase_nxt     = PH_LSA_HI;
            end
            PH_LSA_HI: begin
              cmd.ld_lsa_hi = 1'b1;
              phase_nxt     = PH_CS_LO;
            end
            PH_CS_LO:  phase_nxt = PH_CS_HI;
            PH_CS_HI: begin
              cmd.clr_index = 1'b1;
              if (sts.total_zero) begin
                phase_nxt = PH_HUNT;
                if (sts.type_end) state_nxt = S_MK;
              end else begin
                phase_nxt = PH_SMP_LO;
              end
            end
            PH_SMP_LO: begin
              cmd.ld_smp_lo = 1'b1;
              phase_nxt     = PH_SMP_HI;
            end
            PH_SMP_HI: begin
              cmd.inc_index = 1'b1;
              end_nxt       = sts.last_sample && sts.type_end;
              phase_nxt     = sts.last_sample ? PH_HUNT : PH_SMP_LO;
              if (sts.below_max) begin
                cmd.start_calc = 1'b1;
                state_nxt      = S_CALC;
              end else if (sts.last_sample && sts.type_end) begin
                state_nxt = S_MK;
              end
            end
            default:   phase_nxt = PH_HUNT;
          endcase
        end
      end
      S_CALC: if (sts.calc_done) state_nxt = S_PT;
      S_PT: begin
        if (sts.out_free) begin
          cmd.push_point = 1'b1;
          cmd.point_last = !end_r;
          state_nxt      = end_r ? S_MK : S_IDLE;
        end
      end
      S_MK: begin
        if (sts.out_free) begin
          cmd.push_marker = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      state_r <= S_IDLE;
      end_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      state_r <= state_nxt;
      end_r   <= end_nxt;
    end
  end

  a_point_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_point |-> sts.out_free) else $error("point pushed into full output");
  a_marker_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_marker |-> sts.out_free) else $error("marker pushed into full output");
  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    sts.calc_done |-> state_r == S_CALC) else $error("calc done outside calc");
  a_start_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_calc |=> state_r == S_CALC) else $error("calc start lost");

endmodule

// ===== hdl/lspp_dp.sv =====
`timescale 1ns / 1ps
module lspp_dp
  import lspp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_byte,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  lspp_cmd_t   cmd,
  output lspp_sts_t   sts,
  input  logic        out_tready,
  output logic        out_valid,
  output logic        out_kind,
  output logic [15:0] out_angle,
  output logic [13:0] out_dist,
  output logic [15:0] out_count,
  output logic        out_last
);

  typedef enum logic [2:0] {D_IDLE, D_PREP, D_ITER, D_FIN, D_SUM} dph_t;

  logic [15:0] limit_r, frame_pts_r;
  logic [7:0]  packet_type_r, total_r, idx_r, low_r;
  logic [15:0] fsa_r, lsa_r;

  dph_t               dph_r;
  logic [13:0]        dist_r;
  logic [34:0]        mx_r;
  logic signed [21:0] t_r;
  logic signed [24:0] prod_r;
  logic signed [57:0] x_r, y_r;
  logic signed [31:0] z_r;
  logic [4:0]         k_r;
  logic [23:0]        num_r;
  logic [7:0]         rem_r;
  logic               neg_r;
  logic signed [15:0] corr_r;
  logic signed [24:0] step_r;
  logic [15:0]        angle_r;

  logic               oval_r, okind_r, olast_r;
  logic [15:0]        oang_r, ocnt_r;
  logic [13:0]        odist_r;

  logic [13:0]        d_in;
  logic signed [15:0] diff_c;
  logic signed [24:0] prod_c;
  logic signed [32:0] ymul_c;
  logic signed [57:0] yext_c, xs_c, ys_c;
  logic [24:0]        pmag_c;
  logic [8:0]         rem_sh_c;
  logic               qbit_c;
  logic [31:0]        zmag_c, zrnd_c;
  logic signed [26:0] sum_c;

  assign d_in   = {in_byte, low_r[7:2]};
  assign diff_c = $signed({1'b0, lsa_r[15:1]}) - $signed({1'b0, fsa_r[15:1]});
  assign prod_c = diff_c * $signed({1'b0, idx_r});
  assign ymul_c = 33'(t_r) * 33'sd1916;
  assign yext_c = 58'(ymul_c);
  assign pmag_c = prod_r[24] ? 25'(-prod_r) : 25'(prod_r);
  assign xs_c   = x_r >>> k_r;
  assign ys_c   = y_r >>> k_r;
  assign rem_sh_c = {rem_r, num_r[23]};
  assign qbit_c   = (rem_sh_c >= {1'b0, total_r});
  assign zmag_c = z_r[31] ? 32'(-z_r) : 32'(z_r);
  assign zrnd_c = (zmag_c + 32'd32768) >> 16;
  assign sum_c  = $signed({12'b0, fsa_r[15:1]}) + 27'(step_r) - 27'(corr_r);

  assign sts.is_sync1    = (in_byte == SYNC1);
  assign sts.is_sync2    = (in_byte == SYNC2);
  assign sts.total_zero  = (total_r == 8'd0);
  assign sts.last_sample = (8'(idx_r + 8'd1) >= total_r);
  assign sts.type_end    = (packet_type_r == FRAME_END_TYPE);
  assign sts.below_max   = (frame_pts_r < limit_r);
  assign sts.calc_done   = (dph_r == D_SUM);
  assign sts.out_free    = !oval_r || out_tready;

  // Header and sample registers.
  always_ff @(posedge clk) begin
    if (cmd.ld_type)   packet_type_r <= in_byte;
    if (cmd.ld_count)  total_r       <= in_byte;
    if (cmd.ld_fsa_lo) fsa_r[7:0]    <= in_byte;
    if (cmd.ld_fsa_hi) fsa_r[15:8]   <= in_byte;
    if (cmd.ld_lsa_lo) lsa_r[7:0]    <= in_byte;
    if (cmd.ld_lsa_hi) lsa_r[15:8]   <= in_byte;
    if (cmd.ld_smp_lo) low_r         <= in_byte;
    if (cmd.clr_index)      idx_r <= 8'd0;
    else if (cmd.inc_index) idx_r <= idx_r + 8'd1;
  end

  // Angle unit: CORDIC correction and the interpolation divide share one counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dph_r <= D_IDLE;
    end else begin
      case (dph_r)
        D_IDLE: if (cmd.start_calc) dph_r <= D_PREP;
        D_PREP: dph_r <= D_ITER;
        D_ITER: if (k_r == 5'(CORDIC_STEPS - 1)) dph_r <= D_FIN;
        D_FIN:  dph_r <= D_SUM;
        default: dph_r <= D_IDLE;
      endcase
    end
    case (dph_r)
      D_IDLE: begin
        if (cmd.start_calc) begin
          dist_r <= d_in;
          mx_r   <= XSCALE * {21'b0, d_in};
          t_r    <= $signed(22'(d_in) * 22'd100 - DIST_OFFSET);
          prod_r <= prod_c;
        end
      end
      D_PREP: begin
        x_r   <= $signed({3'b0, mx_r, 20'b0});
        y_r   <= $signed({yext_c[37:0], 20'b0});
        z_r   <= '0;
        k_r   <= '0;
        num_r <= pmag_c[23:0];
        neg_r <= prod_r[24];
        rem_r <= '0;
      end
      D_ITER: begin
        if (!y_r[57]) begin
          x_r <= x_r + ys_c;
          y_r <= y_r - xs_c;
          z_r <= z_r + $signed({3'b0, atan_lut(k_r)});
        end else begin
          x_r <= x_r - ys_c;
          y_r <= y_r + xs_c;
          z_r <= z_r - $signed({3'b0, atan_lut(k_r)});
        end
        rem_r <= qbit_c ? 8'(rem_sh_c - {1'b0, total_r}) : rem_sh_c[7:0];
        num_r <= {num_r[22:0], qbit_c};
        k_r   <= k_r + 5'd1;
      end
      D_FIN: begin
        if (dist_r == 14'd0)  corr_r <= '0;
        else if (z_r[31])     corr_r <= $signed(16'(-zrnd_c));
        else                  corr_r <= $signed(zrnd_c[15:0]);
        step_r <= neg_r ? -$signed({1'b0, num_r}) : $signed({1'b0, num_r});
      end
      D_SUM: begin
        if (sum_c > 27'sd32767)       angle_r <= 16'h7FFF;
        else if (sum_c < -27'sd32768) angle_r <= 16'h8000;
        else                          angle_r <= sum_c[15:0];
      end
      default: ;
    endcase
  end

  // Limit register, frame count and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RST;
      frame_pts_r <= '0;
      oval_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) limit_r <= cfg_wr_data;
      if (cmd.push_point) begin
        oval_r      <= 1'b1;
        frame_pts_r <= frame_pts_r + 16'd1;
      end else if (cmd.push_marker) begin
        oval_r      <= 1'b1;
        frame_pts_r <= '0;
      end else if (out_tready) begin
        oval_r <= 1'b0;
      end
    end
    if (cmd.push_point) begin
      okind_r <= 1'b0;
      oang_r  <= angle_r;
      odist_r <= dist_r;
      ocnt_r  <= '0;
      olast_r <= cmd.point_last;
    end else if (cmd.push_marker) begin
      okind_r <= 1'b1;
      oang_r  <= '0;
      odist_r <= '0;
      ocnt_r  <= frame_pts_r;
      olast_r <= 1'b1;
    end
  end

  assign out_valid = oval_r;
  assign out_kind  = okind_r;
  assign out_angle = oang_r;
  assign out_dist  = odist_r;
  assign out_count = ocnt_r;
  assign out_last  = olast_r;

  a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    oval_r && okind_r |-> olast_r) else $error("marker without last");
  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    oval_r && okind_r |-> odist_r == 14'd0 && oang_r == 16'd0)
    else $error("marker carries point data");
  a_point_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    oval_r && !okind_r |-> ocnt_r == 16'd0) else $error("point carries count");

endmodule

// ===== hdl/lidar_scan_packet_parser.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Ports                     Content
// in       in   in_tvalid/tready/tdata    tdata[7:0] rx_byte
// out      out  out_tvalid/tready/tdata   tdata angle, distance, point_count; tuser kind;
//                                         tlast last
// cfg      in   cfg_wr_en/cfg_wr_data     point limit
//
// Header, sync and low sample bytes are taken one per cycle while no point or marker is in progress.
// The high byte of a sample whose point is kept stalls the input while the angle unit
// runs (setup, 24 CORDIC/divide iterations, rounding, sum) and until the point is loaded
// into the output register; a frame-end marker is loaded after it and stalls as well.
// Reset clears the parse state and the frame count and sets the point limit to 1000.
// A stalled output only blocks input once another result is ready to be loaded.
module lidar_scan_packet_parser
  import lspp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // [15:0] angle, [29:16] distance, [45:30] point_count
  output logic [0:0]  out_tuser,   // [0] kind
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  lspp_cmd_t   cmd;
  lspp_sts_t   sts;
  logic        kind;
  logic [15:0] angle, count;
  logic [13:0] distance;

  lspp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lspp_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_byte     (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_tready  (out_tready),
    .out_valid   (out_tvalid),
    .out_kind    (kind),
    .out_angle   (angle),
    .out_dist    (distance),
    .out_count   (count),
    .out_last    (out_tlast)
  );

  assign out_tdata = {2'b00, count, distance, angle};
  assign out_tuser = kind;

endmodule
